[rtl/core/clq_pkg.sv]
// clq_pkg: shared types and codes of the circular linked queue
// operation and status codes, sequencer states, fixed field widths
// no dependencies
package clq_pkg;

   localparam int OP_W     = 3;
   localparam int NODE_W   = 8;
   localparam int STATUS_W = 2;

   // operation codes; codes above OP_QUERY behave as a query
   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 3'd0,
      OP_APPEND = 3'd1,
      OP_REMOVE = 3'd2,
      OP_TAKE   = 3'd3,
      OP_QUERY  = 3'd4
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_LINKED    = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_CHECK,
      S_LINK2,
      S_TAKE2,
      S_WALK,
      S_UNLINK,
      S_RESP
   } state_type;

endpackage

[rtl/core/clq_req_if.sv]
// clq_req_if: request channel of the circular linked queue
// valid/ready handshake with operation and node payload; uses clq_pkg
interface clq_req_if import clq_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   operation;
   logic [NODE_W-1:0] node;

   modport source (output valid, output operation, output node, input ready);
   modport sink   (input valid, input operation, input node, output ready);
endinterface

[rtl/core/clq_rsp_if.sv]
// clq_rsp_if: response channel of the circular linked queue
// valid/ready handshake with node_out, status and list_empty; uses clq_pkg
interface clq_rsp_if import clq_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [NODE_W-1:0]   node_out;
   logic [STATUS_W-1:0] status;
   logic                list_empty;

   modport source (output valid, output node_out, output status, output list_empty,
                   input ready);
   modport sink   (input valid, input node_out, input status, input list_empty,
                   output ready);
endinterface

[rtl/core/clq_ram.sv]
// clq_ram: generic simple dual port ram, one write and one registered read port
// no dependencies
module clq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/circular_linked_queue.sv]
// circular_linked_queue: circular singly linked list over a node pool, tail pointer
// uses clq_pkg, clq_req_if, clq_rsp_if and clq_ram
//
//  channel   dir  beat contents                       accepted when
//  req_chan  in   operation[2:0], node[7:0]           valid && ready
//  rsp_chan  out  node_out[7:0], status[1:0],         valid && ready
//                 list_empty
//
// states: query and refused requests pass S_CHECK and S_RESP; insert and append on a
//   non-empty list add S_LINK2 (the next-pointer ram has one write port), and take
//   adds S_TAKE2 unless it removes the last node; remove adds one S_WALK step per
//   node walked past the tail, plus S_UNLINK when the node is found; the walk visits
//   at most NODES nodes
// reset: a clearing pass writes the linked-mark ram, one entry a cycle, over all NODES
//   entries after reset; req_chan.ready stays low until it ends
// stalls: a finished response waits in the output register; a new request is taken
//   while it waits, and the sequencer holds only when a second response is ready
module circular_linked_queue import clq_pkg::*; #(
   parameter int NODES = 256
) (
   input  logic      clock,
   input  logic      reset,
   clq_req_if.sink   req_chan,
   clq_rsp_if.source rsp_chan
);

   localparam int IDX_W = $clog2(NODES);

   // sequencer and list registers
   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  clr_ff, clr_in;
   logic [IDX_W-1:0]  tail_ff, tail_in;
   logic              empty_ff, empty_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // per-request payload registers
   logic [OP_W-1:0]   op_ff, op_in;
   logic [NODE_W-1:0] node_ff, node_in;
   logic [IDX_W-1:0]  q_ff, q_in;           // walk position / node taken
   logic              linked_ff, linked_in; // linked mark of the named node
   logic [IDX_W-1:0]  res_node_ff, res_node_in;
   status_type        res_status_ff, res_status_in;
   logic [NODE_W-1:0] rsp_node_ff, rsp_node_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic              rsp_empty_ff, rsp_empty_in;

   // ram ports
   logic              nx_we, lk_we, lk_wdata, lk_rdata;
   logic [IDX_W-1:0]  nx_waddr, nx_wdata, nx_raddr, nx_rdata, lk_waddr, lk_raddr;

   logic              accept, slot_free, rsp_load, in_range;
   logic [IDX_W-1:0]  p_idx, q_cur;
   logic              lk_cur;

   // next pointer of each linked node; never used before written
   clq_ram #(.WIDTH(IDX_W), .DEPTH(NODES)) u_next_ram (
      .clock   (clock),
      .wr_en   (nx_we),
      .wr_addr (nx_waddr),
      .wr_data (nx_wdata),
      .rd_addr (nx_raddr),
      .rd_data (nx_rdata)
   );

   // linked mark of each node; cleared by the pass after reset
   clq_ram #(.WIDTH(1), .DEPTH(NODES)) u_link_ram (
      .clock   (clock),
      .wr_en   (lk_we),
      .wr_addr (lk_waddr),
      .wr_data (lk_wdata),
      .rd_addr (lk_raddr),
      .rd_data (lk_rdata)
   );

   assign slot_free      = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE) || ((state_ff == S_RESP) && slot_free);
   assign accept         = req_chan.valid && req_chan.ready;
   assign rsp_load       = (state_ff == S_RESP) && slot_free;

   // node indices at or above NODES never sit in the list
   assign in_range = {24'd0, node_ff} < 32'(NODES);
   assign p_idx    = IDX_W'(node_ff);

   // first walk step runs in S_CHECK straight from the tail
   assign q_cur  = (state_ff == S_CHECK) ? tail_ff : q_ff;
   assign lk_cur = (state_ff == S_CHECK) ? lk_rdata : linked_ff;

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      tail_in       = tail_ff;
      empty_in      = empty_ff;
      op_in         = op_ff;
      node_in       = node_ff;
      q_in          = q_ff;
      linked_in     = linked_ff;
      res_node_in   = res_node_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_node_in   = rsp_node_ff;
      rsp_status_in = rsp_status_ff;
      rsp_empty_in  = rsp_empty_ff;

      // ram defaults: reads aim at the next request's tail and node
      nx_we    = 1'b0;
      nx_waddr = p_idx;
      nx_wdata = p_idx;
      nx_raddr = tail_ff;
      lk_we    = 1'b0;
      lk_waddr = p_idx;
      lk_wdata = 1'b0;
      lk_raddr = IDX_W'(req_chan.node);

      unique case (state_ff)
         S_CLEAR: begin
            lk_we    = 1'b1;
            lk_waddr = clr_ff;
            clr_in   = clr_ff + IDX_W'(1);
            if (clr_ff == IDX_W'(NODES - 1)) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (accept) begin
               op_in    = req_chan.operation;
               node_in  = req_chan.node;
               state_in = S_CHECK;
            end
         end

         S_CHECK, S_WALK: begin
            // reads of next[tail] and linked[node] land here in S_CHECK, of next[q] in S_WALK
            res_node_in   = '0;
            res_status_in = ST_OK;
            state_in      = S_RESP;
            if (state_ff == S_WALK || op_ff == OP_REMOVE) begin
               if (state_ff == S_CHECK && empty_ff) begin
                  res_status_in = ST_EMPTY;
               end else if (state_ff == S_CHECK && !in_range) begin
                  res_status_in = ST_NOT_FOUND;
               end else begin
                  linked_in = lk_cur;
                  if (nx_rdata == p_idx && lk_cur) begin
                     // predecessor found; fetch the node's own successor
                     q_in     = q_cur;
                     nx_raddr = p_idx;
                     state_in = S_UNLINK;
                  end else if (nx_rdata == tail_ff || nx_rdata == p_idx) begin
                     res_status_in = ST_NOT_FOUND;
                  end else begin
                     q_in     = nx_rdata;
                     nx_raddr = nx_rdata;
                     state_in = S_WALK;
                  end
               end
            end else if (op_ff == OP_INSERT || op_ff == OP_APPEND) begin
               if (!in_range) begin
                  res_status_in = ST_NOT_FOUND;
               end else if (lk_rdata) begin
                  res_status_in = ST_LINKED;
               end else begin
                  lk_we    = 1'b1;
                  lk_wdata = 1'b1;
                  nx_we    = 1'b1;
                  if (empty_ff) begin
                     // lone node points at itself
                     tail_in  = p_idx;
                     empty_in = 1'b0;
                  end else begin
                     nx_wdata = nx_rdata;
                     state_in = S_LINK2;
                  end
               end
            end else if (op_ff == OP_TAKE) begin
               if (empty_ff) begin
                  res_status_in = ST_EMPTY;
               end else begin
                  q_in     = nx_rdata;
                  lk_we    = 1'b1;
                  lk_waddr = nx_rdata;
                  if (nx_rdata == tail_ff) begin
                     tail_in     = '0;
                     empty_in    = 1'b1;
                     res_node_in = nx_rdata;
                  end else begin
                     nx_raddr = nx_rdata;
                     state_in = S_TAKE2;
                  end
               end
            end
         end

         S_LINK2: begin
            // tail now points at the new node
            nx_we         = 1'b1;
            nx_waddr      = tail_ff;
            if (op_ff == OP_APPEND) begin
               tail_in = p_idx;
            end
            res_node_in   = '0;
            res_status_in = ST_OK;
            state_in      = S_RESP;
         end

         S_TAKE2: begin
            // tail skips the taken head
            nx_we         = 1'b1;
            nx_waddr      = tail_ff;
            nx_wdata      = nx_rdata;
            res_node_in   = q_ff;
            res_status_in = ST_OK;
            state_in      = S_RESP;
         end

         S_UNLINK: begin
            // predecessor inherits the removed node's successor
            nx_we    = 1'b1;
            nx_waddr = q_ff;
            nx_wdata = nx_rdata;
            lk_we    = 1'b1;
            if (tail_ff == p_idx) begin
               if (q_ff == p_idx) begin
                  tail_in  = '0;
                  empty_in = 1'b1;
               end else begin
                  tail_in = q_ff;
               end
            end
            res_node_in   = p_idx;
            res_status_in = ST_OK;
            state_in      = S_RESP;
         end

         S_RESP: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_node_in   = NODE_W'(res_node_ff);
               rsp_status_in = res_status_ff;
               rsp_empty_in  = empty_ff;
               if (accept) begin
                  op_in    = req_chan.operation;
                  node_in  = req_chan.node;
                  state_in = S_CHECK;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end

         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         tail_ff      <= '0;
         empty_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         tail_ff      <= tail_in;
         empty_ff     <= empty_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      node_ff       <= node_in;
      q_ff          <= q_in;
      linked_ff     <= linked_in;
      res_node_ff   <= res_node_in;
      res_status_ff <= res_status_in;
      rsp_node_ff   <= rsp_node_in;
      rsp_status_ff <= rsp_status_in;
      rsp_empty_ff  <= rsp_empty_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.node_out   = rsp_node_ff;
   assign rsp_chan.status     = rsp_status_ff;
   assign rsp_chan.list_empty = rsp_empty_ff;

   // an empty list always parks the tail at zero
   a_empty_tail: assert property (@(posedge clock) disable iff (reset)
      empty_ff |-> tail_ff == '0)
      else $error("tail not zero on empty list");

   // a refused or empty answer never names a node
   a_fail_no_node: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != ST_OK |-> rsp_node_ff == '0)
      else $error("node reported with non-ok status");

   // the reported empty flag matches the list right after the beat is loaded
   a_empty_report: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> rsp_empty_ff == empty_ff)
      else $error("list_empty disagrees with list state");

   // the remove walk only runs over a non-empty list
   a_walk_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_WALK || state_ff == S_UNLINK |-> !empty_ff)
      else $error("walk on empty list");

endmodule

[test/clq_checker.sv]
// clq_checker: watches the request and response channels of circular_linked_queue,
// keeps its own copy of the list and compares every response beat in order
// depends on clq_pkg, clq_req_if and clq_rsp_if
module clq_checker import clq_pkg::*; #(
   parameter int POOL = 256
) (
   input  logic clock,
   input  logic reset,
   clq_req_if   req_mon,
   clq_rsp_if   rsp_mon,
   output int   fails,
   output int   due
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [NODE_W-1:0] node_out;
      status_type        status;
      logic              list_empty;
   } list_answer_type;

   logic [NODE_W-1:0] succ [POOL];
   bit                on_list [POOL];
   logic [NODE_W-1:0] tail;
   bit                is_empty;
   list_answer_type   answers_due [$];

   // applies one operation to the shadow list and returns the answer it gives
   function automatic list_answer_type apply_list_op(input logic [OP_W-1:0] op,
                                                     input logic [NODE_W-1:0] nd);
      list_answer_type   ans;
      logic [NODE_W-1:0] q;
      int                steps;
      ans.node_out = '0;
      ans.status   = ST_OK;
      case (op)
         OP_INSERT, OP_APPEND: begin
            if (int'(nd) >= POOL) begin
               ans.status = ST_NOT_FOUND;
            end else if (on_list[nd]) begin
               ans.status = ST_LINKED;
            end else begin
               if (is_empty) begin
                  succ[nd] = nd;
                  tail     = nd;
                  is_empty = 1'b0;
               end else begin
                  succ[nd]   = succ[tail];
                  succ[tail] = nd;
                  if (op == OP_APPEND) tail = nd;
               end
               on_list[nd] = 1'b1;
            end
         end
         OP_REMOVE: begin
            if (is_empty) begin
               ans.status = ST_EMPTY;
            end else if (int'(nd) >= POOL) begin
               ans.status = ST_NOT_FOUND;
            end else begin
               // walk from the tail looking for the predecessor
               q     = tail;
               steps = 0;
               while (succ[q] != tail && succ[q] != nd && steps < POOL) begin
                  q = succ[q];
                  steps++;
               end
               if (succ[q] == nd && on_list[nd]) begin
                  succ[q]     = succ[nd];
                  succ[nd]    = '0;
                  on_list[nd] = 1'b0;
                  if (tail == nd) begin
                     if (q == nd) begin
                        tail     = '0;
                        is_empty = 1'b1;
                     end else begin
                        tail = q;
                     end
                  end
                  ans.node_out = nd;
               end else begin
                  ans.status = ST_NOT_FOUND;
               end
            end
         end
         OP_TAKE: begin
            if (is_empty) begin
               ans.status = ST_EMPTY;
            end else begin
               q          = succ[tail];
               succ[tail] = succ[q];
               succ[q]    = '0;
               on_list[q] = 1'b0;
               if (q == tail) begin
                  tail     = '0;
                  is_empty = 1'b1;
               end
               ans.node_out = q;
            end
         end
         default: ;  // query and spare codes change nothing
      endcase
      ans.list_empty = is_empty;
      return ans;
   endfunction

   task automatic flag_field(input string field, input int want, input int seen);
      if (fails < 50)
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, seen);
      fails++;
   endtask

   always @(posedge clock) begin
      list_answer_type want;
      if (reset) begin
         foreach (succ[i]) begin
            succ[i]    = '0;
            on_list[i] = 1'b0;
         end
         tail     = '0;
         is_empty = 1'b1;
         answers_due.delete();
         fails = 0;
      end else begin
         // response first: it can never belong to a request beat at this edge
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (answers_due.size() == 0) begin
               if (fails < 50)
                  $display("%0t ns: response beat with nothing expected, node_out %0d",
                           $time, rsp_mon.node_out);
               fails++;
            end else begin
               want = answers_due.pop_front();
               if (rsp_mon.node_out !== want.node_out)
                  flag_field("node_out", want.node_out, rsp_mon.node_out);
               if (rsp_mon.status !== want.status)
                  flag_field("status", want.status, rsp_mon.status);
               if (rsp_mon.list_empty !== want.list_empty)
                  flag_field("list_empty", want.list_empty, rsp_mon.list_empty);
            end
         end
         if (req_mon.valid && req_mon.ready)
            answers_due.push_back(apply_list_op(req_mon.operation, req_mon.node));
      end
      due = answers_due.size();
   end

endmodule

[test/tb.sv]
// tb: top of the circular_linked_queue testbench, makes request and ready stimulus
// and gives the verdict; checking is done by clq_checker beside the block
// depends on clq_pkg, clq_req_if, clq_rsp_if, clq_checker and circular_linked_queue
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import clq_pkg::*;

   // slowest legal run is roughly 2000 beats of full 256-node walks plus stalls;
   // this stays several times above that, clearing pass included
   localparam int LIMIT    = 2_000_000;
   localparam int PHASES   = 8;
   localparam int PER_PHASE = 240;
   // request beats after which the long response hold-off starts
   localparam int HOLD_AT  = 400;
   localparam int HOLD_LEN = 400;
   // from this many request beats on, neither side idles
   localparam int CALM_AT  = 1650;

   logic clock = 1'b0;
   logic reset;
   int   cycles = 0;
   int   req_beats = 0;
   int   fails;
   int   due;

   clq_req_if req_chan ();
   clq_rsp_if rsp_chan ();

   circular_linked_queue #(.NODES(256)) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   clq_checker #(.POOL(256)) u_checker (
      .clock   (clock),
      .reset   (reset),
      .req_mon (req_chan),
      .rsp_mon (rsp_chan),
      .fails   (fails),
      .due     (due)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // watchdog on the whole run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT) begin
         $display("circular_linked_queue verification failed");
         $finish;
      end
   end

   // request beats taken so far, steers the hold-off and the calm tail
   always @(posedge clock) begin
      if (!reset && req_chan.valid && req_chan.ready) req_beats <= req_beats + 1;
   end

   // offer one request beat and hold it until the block takes it;
   // valid stays high on return so back-to-back beats need no lowering
   task automatic push_req(input logic [OP_W-1:0] op, input logic [NODE_W-1:0] nd);
      req_chan.valid     <= 1'b1;
      req_chan.operation <= op;
      req_chan.node      <= nd;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // sampled at the falling edge so the checker's count is settled
   task automatic wait_drained();
      do @(negedge clock); while (due != 0);
      @(posedge clock);
   endtask

   // node picker: a sliding window of 16 gives repeats (already linked, remove hits),
   // the extremes hit every bit, the rest spreads over the whole pool
   function automatic logic [NODE_W-1:0] pick_node(input int window);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 40) return NODE_W'(window + $urandom_range(0, 15));
      if (roll < 45) return '0;
      if (roll < 50) return '1;
      return NODE_W'($urandom_range(0, 255));
   endfunction

   // response side: random ready bursts, one long hold-off, always ready at the end
   initial begin
      bit held;
      held = 1'b0;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!held && req_beats >= HOLD_AT) begin
            // long hold-off: the block fills up and stops taking requests
            held = 1'b1;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_LEN) @(posedge clock);
         end else if (req_beats < CALM_AT && $urandom_range(0, 3) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   // request side and verdict
   initial begin
      int unsigned       roll;
      int                window;
      bit                growing;
      logic [OP_W-1:0]   op;

      reset              <= 1'b1;
      req_chan.valid     <= 1'b0;
      req_chan.operation <= OP_QUERY;
      req_chan.node      <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed beats; ready stays low through the clearing pass
      push_req(OP_QUERY, 8'd0);      // query on the empty list
      push_req(OP_TAKE, 8'd0);       // take on empty
      push_req(OP_REMOVE, 8'd5);     // remove on empty
      push_req(OP_INSERT, 8'd0);     // first node into an empty list
      push_req(OP_INSERT, 8'd0);     // already linked
      push_req(OP_APPEND, 8'd255);   // new tail
      push_req(OP_APPEND, 8'd255);   // already linked at the tail
      push_req(OP_INSERT, 8'd128);   // new head
      push_req(OP_REMOVE, 8'd77);    // walk goes all the way round, not found
      push_req(OP_REMOVE, 8'd255);   // remove the tail, predecessor becomes tail
      push_req(OP_REMOVE, 8'd128);   // remove the head
      push_req(OP_TAKE, 8'd0);       // take the last node, list empties
      push_req(OP_APPEND, 8'd1);
      push_req(OP_APPEND, 8'd2);
      push_req(OP_APPEND, 8'd3);
      push_req(OP_REMOVE, 8'd2);     // remove from the middle
      push_req(3'(OP_QUERY + 3'd1), 8'd255);  // spare codes act as a query
      push_req(3'(OP_QUERY + 3'd2), 8'd170);
      push_req(3'(OP_QUERY + 3'd3), 8'd0);
      push_req(OP_TAKE, 8'd0);       // head 1 leaves, 3 remains alone
      push_req(OP_REMOVE, 8'd3);     // remove the only node, which is the tail
      push_req(OP_REMOVE, 8'd255);   // remove on empty again

      // random part: phases that grow or shrink the list, so walks get long
      for (int ph = 0; ph < PHASES; ph++) begin
         growing = (ph == 0 || ph == 1 || ph == 3 || ph == 6);
         window  = $urandom_range(0, 240);
         if (ph == 4) begin
            // sender pause: let every outstanding response come back first
            req_chan.valid <= 1'b0;
            wait_drained();
         end
         for (int k = 0; k < PER_PHASE; k++) begin
            roll = $urandom_range(0, 99);
            if (growing) begin
               if (roll < 40)      op = OP_INSERT;
               else if (roll < 75) op = OP_APPEND;
               else if (roll < 85) op = OP_REMOVE;
               else if (roll < 93) op = OP_TAKE;
               else if (roll < 97) op = OP_QUERY;
               else                op = 3'(OP_QUERY + $urandom_range(1, 3));
            end else begin
               if (roll < 10)      op = OP_INSERT;
               else if (roll < 20) op = OP_APPEND;
               else if (roll < 65) op = OP_REMOVE;
               else if (roll < 90) op = OP_TAKE;
               else if (roll < 95) op = OP_QUERY;
               else                op = 3'(OP_QUERY + $urandom_range(1, 3));
            end
            // occasional idle burst before the beat, none in the calm tail
            if (req_beats < CALM_AT && $urandom_range(0, 4) == 0) begin
               req_chan.valid <= 1'b0;
               repeat ($urandom_range(1, 9)) @(posedge clock);
            end
            push_req(op, pick_node(window));
            if ($urandom_range(0, 59) == 0) window = $urandom_range(0, 240);
         end
      end

      req_chan.valid <= 1'b0;
      wait_drained();
      // a walk can run most of the pool, give any stray beat time to show
      repeat (300) @(posedge clock);
      if (fails == 0 && due == 0) begin
         $display("circular_linked_queue verification clean");
      end else begin
         $display("circular_linked_queue verification failed");
      end
      $finish;
   end

endmodule
